// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Request and status codes, entry layout, controller states and the
// command/status groups that join controller and datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int ID_W    = 16;
    localparam int PRIO_W  = 8;
    localparam int STAMP_W = 32;
    localparam int ENTRY_W = ID_W + PRIO_W + STAMP_W;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;
    localparam logic [1:0] REQ_NOP    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_EV,
        S_FIND_RD,
        S_FIND_EV,
        S_REM_CHK,
        S_REM_EV,
        S_PL_START,
        S_PH_EV,
        S_SC_CHK,
        S_SC_EV,
        S_SH_CHK,
        S_SH_EV,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_RD_IDX,
        OP_RD_IDX1,
        OP_RD_IDXM1,
        OP_RD_POS,
        OP_RD_HEAD,
        OP_POP_CAP,
        OP_FIND_HIT,
        OP_IDX_INC,
        OP_REM_WR,
        OP_REM_END,
        OP_PLACE_AT0,
        OP_POS1,
        OP_POS_INC,
        OP_SH_INIT,
        OP_SH_WR,
        OP_PLACE_WR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       set_status;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       empty;
        logic       id_hit;
        logic       ahead;
        logic       pass_ok;
        logic       rem_more;
        logic       scan_more;
        logic       shift_more;
        logic       find_last;
    } stat_t;

endpackage

// ===== rtl/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl: request sequencer
// Walks each request through scan, remove and placement steps and issues
// one datapath command per cycle.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     req_type,
    input  spq_pkg::stat_t stat,
    output spq_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // advance state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        spq_pkg::REQ_INSERT:
                            state_next = stat.full ? spq_pkg::S_DONE : spq_pkg::S_PL_START;
                        spq_pkg::REQ_POP:
                            state_next = stat.empty ? spq_pkg::S_DONE : spq_pkg::S_POP_RD;
                        spq_pkg::REQ_UPDATE:
                            state_next = stat.empty ? spq_pkg::S_DONE : spq_pkg::S_FIND_RD;
                        default:
                            state_next = spq_pkg::S_DONE;
                    endcase
                end
            end
            spq_pkg::S_POP_RD:  state_next = spq_pkg::S_POP_EV;
            spq_pkg::S_POP_EV:  state_next = spq_pkg::S_REM_CHK;
            spq_pkg::S_FIND_RD: state_next = spq_pkg::S_FIND_EV;
            spq_pkg::S_FIND_EV:
            begin
                if (stat.id_hit)
                    state_next = spq_pkg::S_REM_CHK;
                else if (stat.find_last)
                    state_next = spq_pkg::S_DONE;
                else
                    state_next = spq_pkg::S_FIND_RD;
            end
            spq_pkg::S_REM_CHK:
            begin
                if (stat.rem_more)
                    state_next = spq_pkg::S_REM_EV;
                else if (stat.req == spq_pkg::REQ_UPDATE)
                    state_next = spq_pkg::S_PL_START;
                else
                    state_next = spq_pkg::S_DONE;
            end
            spq_pkg::S_REM_EV: state_next = spq_pkg::S_REM_CHK;
            spq_pkg::S_PL_START:
                state_next = stat.empty ? spq_pkg::S_SH_CHK : spq_pkg::S_PH_EV;
            spq_pkg::S_PH_EV:
                state_next = stat.ahead ? spq_pkg::S_SH_CHK : spq_pkg::S_SC_CHK;
            spq_pkg::S_SC_CHK:
                state_next = stat.scan_more ? spq_pkg::S_SC_EV : spq_pkg::S_SH_CHK;
            spq_pkg::S_SC_EV:
                state_next = stat.pass_ok ? spq_pkg::S_SC_CHK : spq_pkg::S_SH_CHK;
            spq_pkg::S_SH_CHK:
                state_next = stat.shift_more ? spq_pkg::S_SH_EV : spq_pkg::S_DONE;
            spq_pkg::S_SH_EV: state_next = spq_pkg::S_SH_CHK;
            spq_pkg::S_DONE:  state_next = spq_pkg::S_IDLE;
            default:          state_next = spq_pkg::S_IDLE;
        endcase
    end

    // drive datapath commands
    always_comb
    begin
        cmd.op         = spq_pkg::OP_NONE;
        cmd.set_status = 1'b0;
        cmd.status     = spq_pkg::ST_OK;
        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.op         = spq_pkg::OP_LATCH;
                    cmd.set_status = 1'b1;
                    if (req_type == spq_pkg::REQ_INSERT && stat.full)
                        cmd.status = spq_pkg::ST_FULL;
                    else if (req_type == spq_pkg::REQ_POP && stat.empty)
                        cmd.status = spq_pkg::ST_EMPTY;
                    else if (req_type == spq_pkg::REQ_UPDATE && stat.empty)
                        cmd.status = spq_pkg::ST_NOTFOUND;
                end
            end
            spq_pkg::S_POP_RD:  cmd.op = spq_pkg::OP_RD_IDX;
            spq_pkg::S_POP_EV:  cmd.op = spq_pkg::OP_POP_CAP;
            spq_pkg::S_FIND_RD: cmd.op = spq_pkg::OP_RD_IDX;
            spq_pkg::S_FIND_EV:
            begin
                if (stat.id_hit)
                begin
                    cmd.op = spq_pkg::OP_FIND_HIT;
                end
                else if (stat.find_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = spq_pkg::ST_NOTFOUND;
                end
                else
                begin
                    cmd.op = spq_pkg::OP_IDX_INC;
                end
            end
            spq_pkg::S_REM_CHK:
                cmd.op = stat.rem_more ? spq_pkg::OP_RD_IDX1 : spq_pkg::OP_REM_END;
            spq_pkg::S_REM_EV: cmd.op = spq_pkg::OP_REM_WR;
            spq_pkg::S_PL_START:
                cmd.op = stat.empty ? spq_pkg::OP_PLACE_AT0 : spq_pkg::OP_RD_HEAD;
            spq_pkg::S_PH_EV:
                cmd.op = stat.ahead ? spq_pkg::OP_PLACE_AT0 : spq_pkg::OP_POS1;
            spq_pkg::S_SC_CHK:
                cmd.op = stat.scan_more ? spq_pkg::OP_RD_POS : spq_pkg::OP_SH_INIT;
            spq_pkg::S_SC_EV:
                cmd.op = stat.pass_ok ? spq_pkg::OP_POS_INC : spq_pkg::OP_SH_INIT;
            spq_pkg::S_SH_CHK:
                cmd.op = stat.shift_more ? spq_pkg::OP_RD_IDXM1 : spq_pkg::OP_PLACE_WR;
            spq_pkg::S_SH_EV: cmd.op = spq_pkg::OP_SH_WR;
            default:          cmd.op = spq_pkg::OP_NONE;
        endcase
    end

    assign busy = (state_reg != spq_pkg::S_IDLE);
    assign done = (state_reg == spq_pkg::S_DONE);

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("sequencer did not return to idle after result");
`endif

endmodule

// ===== rtl/spq_dp.sv =====
// ----------------------------------------------------------------------------
// spq_dp: queue datapath
// Entry RAM in queue order, count, stamp counter, scan pointers, compare
// logic and result registers.
// ----------------------------------------------------------------------------
module spq_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  spq_pkg::cmd_t               cmd,
    input  logic [1:0]                  req_type,
    input  logic [spq_pkg::ID_W-1:0]    entry_id,
    input  logic [spq_pkg::PRIO_W-1:0]  priority_req,
    output spq_pkg::stat_t              stat,
    output logic [1:0]                  status,
    output logic [spq_pkg::ID_W-1:0]    out_id,
    output logic [spq_pkg::PRIO_W-1:0]  out_priority,
    output logic [spq_pkg::STAMP_W-1:0] out_arrival,
    output logic [4:0]                  waiting_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam int ST_LO = 0;
    localparam int PR_LO = spq_pkg::STAMP_W;
    localparam int ID_LO = spq_pkg::STAMP_W + spq_pkg::PRIO_W;

    logic [CW-1:0]                  held_reg;
    logic [spq_pkg::STAMP_W-1:0]    counter_reg;
    logic [CW-1:0]                  idx_reg;
    logic [CW-1:0]                  pos_reg;
    logic [1:0]                     req_reg;
    logic [spq_pkg::ID_W-1:0]       id_reg;
    logic [spq_pkg::PRIO_W-1:0]     prio_reg;
    logic [spq_pkg::STAMP_W-1:0]    stamp_reg;
    logic [1:0]                     status_reg;
    logic [spq_pkg::ID_W-1:0]       oid_reg;
    logic [spq_pkg::PRIO_W-1:0]     oprio_reg;
    logic [spq_pkg::STAMP_W-1:0]    oarr_reg;

    logic                           we;
    logic [AW-1:0]                  waddr;
    logic [spq_pkg::ENTRY_W-1:0]    wdata;
    logic [CW-1:0]                  raddr_w;
    logic [spq_pkg::ENTRY_W-1:0]    rdata;
    logic [spq_pkg::ID_W-1:0]       r_id;
    logic [spq_pkg::PRIO_W-1:0]     r_prio;
    logic [spq_pkg::STAMP_W-1:0]    r_stamp;
    logic [CW+4:0]                  held_ext;

    assign r_id    = rdata[ID_LO +: spq_pkg::ID_W];
    assign r_prio  = rdata[PR_LO +: spq_pkg::PRIO_W];
    assign r_stamp = rdata[ST_LO +: spq_pkg::STAMP_W];

    // select read address
    always_comb
    begin
        case (cmd.op)
            spq_pkg::OP_RD_IDX:   raddr_w = idx_reg;
            spq_pkg::OP_RD_IDX1:  raddr_w = idx_reg + CW'(1);
            spq_pkg::OP_RD_IDXM1: raddr_w = idx_reg - CW'(1);
            spq_pkg::OP_RD_POS:   raddr_w = pos_reg;
            default:              raddr_w = '0;
        endcase
    end

    // select write
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rdata;
        case (cmd.op)
            spq_pkg::OP_REM_WR,
            spq_pkg::OP_SH_WR:
            begin
                we = 1'b1;
            end
            spq_pkg::OP_PLACE_WR:
            begin
                we    = 1'b1;
                waddr = pos_reg[AW-1:0];
                wdata = {id_reg, prio_reg, stamp_reg};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_w[AW-1:0]),
        .rdata (rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            counter_reg <= '0;
            status_reg  <= spq_pkg::ST_OK;
            req_reg     <= spq_pkg::REQ_NOP;
            idx_reg     <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
            case (cmd.op)
                spq_pkg::OP_LATCH:
                begin
                    req_reg <= req_type;
                    idx_reg <= '0;
                    pos_reg <= '0;
                end
                spq_pkg::OP_FIND_HIT:  pos_reg <= idx_reg;
                spq_pkg::OP_IDX_INC:   idx_reg <= idx_reg + CW'(1);
                spq_pkg::OP_REM_WR:    idx_reg <= idx_reg + CW'(1);
                spq_pkg::OP_REM_END:   held_reg <= held_reg - CW'(1);
                spq_pkg::OP_PLACE_AT0:
                begin
                    pos_reg <= '0;
                    idx_reg <= held_reg;
                end
                spq_pkg::OP_POS1:      pos_reg <= CW'(1);
                spq_pkg::OP_POS_INC:   pos_reg <= pos_reg + CW'(1);
                spq_pkg::OP_SH_INIT:   idx_reg <= held_reg;
                spq_pkg::OP_SH_WR:     idx_reg <= idx_reg - CW'(1);
                spq_pkg::OP_PLACE_WR:
                begin
                    held_reg <= held_reg + CW'(1);
                    if (req_reg == spq_pkg::REQ_INSERT)
                    begin
                        counter_reg <= counter_reg + 32'd1;
                    end
                end
                default:
                begin
                    held_reg <= held_reg;
                end
            endcase
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            spq_pkg::OP_LATCH:
            begin
                id_reg    <= entry_id;
                prio_reg  <= priority_req;
                stamp_reg <= counter_reg;
                oid_reg   <= '0;
                oprio_reg <= '0;
                oarr_reg  <= '0;
            end
            spq_pkg::OP_POP_CAP:
            begin
                oid_reg   <= r_id;
                oprio_reg <= r_prio;
                oarr_reg  <= r_stamp;
            end
            spq_pkg::OP_FIND_HIT: stamp_reg <= r_stamp;
            default:              stamp_reg <= stamp_reg;
        endcase
    end

    // compare and status flags
    always_comb
    begin
        stat.req        = req_reg;
        stat.full       = (held_reg >= CAP_C);
        stat.empty      = (held_reg == '0);
        stat.id_hit     = (r_id == id_reg);
        stat.ahead      = (prio_reg > r_prio) ||
                          (prio_reg == r_prio && stamp_reg < r_stamp);
        stat.pass_ok    = (r_prio > prio_reg) ||
                          (r_prio == prio_reg && r_stamp < stamp_reg);
        stat.rem_more   = ((idx_reg + CW'(1)) < held_reg);
        stat.scan_more  = (pos_reg < held_reg);
        stat.shift_more = (idx_reg > pos_reg);
        stat.find_last  = ((idx_reg + CW'(1)) == held_reg);
    end

    assign held_ext      = {5'd0, held_reg};
    assign waiting_count = held_ext[4:0];
    assign status        = status_reg;
    assign out_id        = oid_reg;
    assign out_priority  = oprio_reg;
    assign out_arrival   = oarr_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CAP_C)
        else $error("entry count beyond capacity");
    a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == spq_pkg::OP_PLACE_WR) |-> (held_reg < CAP_C))
        else $error("placement into a full queue");
    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == spq_pkg::OP_REM_END) |-> (held_reg != '0))
        else $error("removal from an empty queue");
`endif

endmodule

// ===== rtl/stable_priority_queue_update_core.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_update_core: bounded priority queue with key update
// Insert, pop and priority update on a queue kept in priority/arrival order.
// ----------------------------------------------------------------------------
// Usage: raise start with req_type, entry_id and priority_req while busy is
// low; the request is taken at that edge. Exactly one result follows, shown
// for a single cycle with done high; the receiver cannot stall it, so capture
// it then. Entries live in one RAM with a single read and a single write
// port, and every step that touches an entry is a read and then a use of the
// registered data. An update searches for the entry, closes the gap, then
// places it again. Rejected requests and the unused request code go straight
// to the result without touching the queue.
module stable_priority_queue_update_core #(
    parameter int CAPACITY = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  req_type,
    input  logic [spq_pkg::ID_W-1:0]    entry_id,
    input  logic [spq_pkg::PRIO_W-1:0]  priority_req,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [spq_pkg::ID_W-1:0]    out_id,
    output logic [spq_pkg::PRIO_W-1:0]  out_priority,
    output logic [spq_pkg::STAMP_W-1:0] out_arrival,
    output logic [4:0]                  waiting_count
);

    spq_pkg::cmd_t  cmd;
    spq_pkg::stat_t stat;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .req_type      (req_type),
        .entry_id      (entry_id),
        .priority_req  (priority_req),
        .stat          (stat),
        .status        (status),
        .out_id        (out_id),
        .out_priority  (out_priority),
        .out_arrival   (out_arrival),
        .waiting_count (waiting_count)
    );

endmodule
